FILE: src/rrng_pkg.sv
// Shared constants, state codes and control bundles of the ranged random number generator.
package rrng_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned RangeW  = 16;
  localparam int unsigned StepW   = 9;
  localparam int unsigned InDataW = 64;

  localparam logic [ValueW-1:0] LcgMul    = 32'd1664525;
  localparam logic [ValueW-1:0] LcgAdd    = 32'd1013904223;
  localparam logic [ValueW-1:0] MtInitMul = 32'd1812433253;
  localparam logic [ValueW-1:0] MtMatrix  = 32'h9908B0DF;
  localparam logic [StepW-1:0]  MtShiftPos = 9'd397;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEED   = 7'b0000010,
    ST_LCG    = 7'b0000100,
    ST_WALK   = 7'b0001000,
    ST_TEMPER = 7'b0010000,
    ST_SCALE  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load_in;
    logic mul_seed;
    logic lcg_step;
    logic walk_step;
    logic temper;
    logic scale;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic twist;
    logic walk_last;
  } sts_t;

endpackage

FILE: src/rrng_ctrl.sv
// Controller state machine of the ranged random number generator.
module rrng_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  rrng_pkg::sts_t sts_i,
  output rrng_pkg::cmd_t cmd_o
);

  rrng_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      rrng_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_d       = rrng_pkg::ST_SEED;
        end
      end
      rrng_pkg::ST_SEED: begin
        cmd_o.mul_seed = 1'b1;
        state_d        = sts_i.twist ? rrng_pkg::ST_WALK : rrng_pkg::ST_LCG;
      end
      rrng_pkg::ST_LCG: begin
        cmd_o.lcg_step = 1'b1;
        state_d        = rrng_pkg::ST_SCALE;
      end
      rrng_pkg::ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = rrng_pkg::ST_TEMPER;
        end
      end
      rrng_pkg::ST_TEMPER: begin
        cmd_o.temper = 1'b1;
        state_d      = rrng_pkg::ST_SCALE;
      end
      rrng_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = rrng_pkg::ST_DONE;
      end
      rrng_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.load_out = 1'b1;
          state_d        = rrng_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrng_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrng_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready = (state_q == rrng_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;

endmodule

FILE: src/rrng_dp.sv
// Datapath of the ranged random number generator: shared multiplier, seeding walk, scaling.
module rrng_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrng_pkg::ValueW-1:0]   cfg_wdata_i,
  input  logic [rrng_pkg::InDataW-1:0]  in_data_i,
  input  logic                          in_twist_i,
  output logic [rrng_pkg::RangeW-1:0]   out_data_o,
  input  rrng_pkg::cmd_t                cmd_i,
  output rrng_pkg::sts_t                sts_o
);

  logic [rrng_pkg::ValueW-1:0] default_seed_q;
  logic [rrng_pkg::ValueW-1:0] last_q;
  logic [rrng_pkg::ValueW-1:0] seed_q;
  logic [rrng_pkg::ValueW-1:0] acc_q, acc_d;
  logic [rrng_pkg::ValueW-1:0] e0_q, e1_q;
  logic [rrng_pkg::StepW-1:0]  step_q;
  logic [rrng_pkg::RangeW-1:0] max_q, min_q;
  logic                        twist_q;
  logic [rrng_pkg::ValueW-1:0] scale_q;
  logic [rrng_pkg::RangeW-1:0] out_q;

  logic [rrng_pkg::ValueW-1:0]   mul_a, mul_b, mul_c;
  logic [2*rrng_pkg::ValueW-1:0] mul_full;
  logic [rrng_pkg::ValueW-1:0]   mul_res;
  logic [rrng_pkg::ValueW-1:0]   in_seed;
  logic [rrng_pkg::ValueW-1:0]   mix_y, twist_y, tempered;
  logic signed [rrng_pkg::RangeW:0]   span;
  logic signed [rrng_pkg::RangeW:0]   frac;
  logic signed [2*rrng_pkg::RangeW+1:0] scale_full;
  logic signed [rrng_pkg::ValueW-1:0] scale_shr;

  assign in_seed = in_data_i[63:32];

  // one shared 32-bit multiply-add, low word only
  always_comb begin
    mul_a = acc_q;
    mul_b = rrng_pkg::LcgMul;
    mul_c = rrng_pkg::LcgAdd;
    if (cmd_i.mul_seed) begin
      mul_a = last_q;
      mul_b = seed_q;
      mul_c = '0;
    end else if (cmd_i.walk_step) begin
      mul_a = acc_q ^ (acc_q >> 30);
      mul_b = rrng_pkg::MtInitMul;
      mul_c = {{(rrng_pkg::ValueW-rrng_pkg::StepW){1'b0}}, step_q};
    end
    mul_full = mul_a * mul_b;
    mul_res  = mul_full[rrng_pkg::ValueW-1:0] + mul_c;
  end

  // twist of entry 0 against entry 397, then tempering
  always_comb begin
    mix_y    = {e0_q[31], e1_q[30:0]};
    twist_y  = acc_q ^ (mix_y >> 1) ^ (mix_y[0] ? rrng_pkg::MtMatrix : '0);
    tempered = twist_y ^ (twist_y >> 11);
    tempered = tempered ^ ((tempered << 7) & 32'h9D2C5680);
    tempered = tempered ^ ((tempered << 15) & 32'hEFC60000);
    tempered = tempered ^ (tempered >> 18);
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_seed || cmd_i.walk_step || cmd_i.lcg_step) begin
      acc_d = mul_res;
    end else if (cmd_i.temper) begin
      acc_d = tempered;
    end
  end

  assign span       = $signed({max_q[15], max_q}) - $signed({min_q[15], min_q});
  assign frac       = $signed({2'b00, acc_q[30:16]});
  assign scale_full = frac * span;
  // floor division by 2^15
  assign scale_shr  = $signed(scale_q) >>> 15;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_seed_q <= 32'd1;
      last_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        default_seed_q <= cfg_wdata_i;
      end
      if (cmd_i.scale) begin
        last_q <= acc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load_in) begin
      max_q   <= in_data_i[15:0];
      min_q   <= in_data_i[31:16];
      seed_q  <= (in_seed == 32'd1) ? default_seed_q : in_seed;
      twist_q <= in_twist_i;
    end
    if (cmd_i.mul_seed) begin
      e0_q   <= mul_res;
      step_q <= {{(rrng_pkg::StepW-1){1'b0}}, 1'b1};
    end
    if (cmd_i.walk_step) begin
      step_q <= step_q + 1'b1;
      if (step_q == {{(rrng_pkg::StepW-1){1'b0}}, 1'b1}) begin
        e1_q <= mul_res;
      end
    end
    if (cmd_i.scale) begin
      scale_q <= scale_full[rrng_pkg::ValueW-1:0];
    end
    if (cmd_i.load_out) begin
      out_q <= scale_shr[rrng_pkg::RangeW-1:0] + min_q;
    end
  end

  assign sts_o.twist     = twist_q;
  assign sts_o.walk_last = (step_q == rrng_pkg::MtShiftPos);
  assign out_data_o      = out_q;

endmodule

FILE: src/ranged_random_number_generator.sv
// Top level of the ranged random number generator.
//
// Input stream: one transaction per request. tdata carries range_max, range_min
// and seed_factor; tuser carries use_twister. A seed_factor of 1 selects the
// default seed factor written through cfg_we_i / cfg_wdata_i while idle.
// Output stream: one transaction per request, tdata carries random_value.
// The request passes the states SEED, LCG, SCALE and DONE in linear
// congruential mode, or SEED, WALK, TEMPER, SCALE and DONE in twister mode.
// One request is in work at a time; the next is taken as soon as the result
// sits in the output register. The twister seeding walk runs 397 steps
// through the single shared 32-bit multiplier, one step a cycle, which makes
// twister mode the slower of the two modes.
// Reset clears the last value to zero and the default seed factor to one;
// no clearing pass is needed. When the receiver stalls, the result holds in
// the output register and the block finishes at most one more request, then
// waits with s_axis_tready low until the output register drains.
module ranged_random_number_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // range_max[15:0], range_min[31:16], seed_factor[63:32]
  input  logic        s_axis_tuser,  // use_twister[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // random_value[15:0]
);

  rrng_pkg::cmd_t cmd;
  rrng_pkg::sts_t sts;

  rrng_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  rrng_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_twist_i  (s_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

FILE: src/rrng_checker.sv
// Port-level checker of the ranged random number generator, bound to the top level.
module rrng_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // one request in work: input closes right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a request is in work");

  // a result never appears on the cycle right after its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared too early");

  // a result needs a request: input must be closed while output rises
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready) == 1'b0)
    else $error("result rose while block was idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

endmodule

bind ranged_random_number_generator rrng_checker u_rrng_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
